### rtl/utv_pkg.sv
package utv_pkg;

   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned CountWidth = 16;
   localparam int unsigned CpWidth    = 21;
   localparam int unsigned DataWidth  = 24;

   localparam logic [CountWidth-1:0] CountMax     = 16'hFFFF;
   localparam logic [CountWidth-1:0] MaxLenReset  = 16'd160;
   localparam logic [ByteWidth-1:0]  CtrlLimit    = 8'h20;
   localparam logic [ByteWidth-1:0]  DelByte      = 8'h7F;
   localparam logic [ByteWidth-1:0]  Lead2Low     = 8'hC2;
   localparam logic [ByteWidth-1:0]  Lead2High    = 8'hDF;
   localparam logic [ByteWidth-1:0]  Lead3Low     = 8'hE0;
   localparam logic [ByteWidth-1:0]  Lead3High    = 8'hEF;
   localparam logic [ByteWidth-1:0]  Lead4Low     = 8'hF0;
   localparam logic [ByteWidth-1:0]  Lead4High    = 8'hF4;
   localparam logic [CpWidth-1:0]    CpMax        = 21'h10FFFF;
   localparam logic [CpWidth-1:0]    SurrLow      = 21'h00D800;
   localparam logic [CpWidth-1:0]    SurrHigh     = 21'h00DFFF;

   // sequence length classes
   localparam logic [1:0] ClassNone = 2'd0;
   localparam logic [1:0] ClassTwo  = 2'd1;
   localparam logic [1:0] ClassThree = 2'd2;
   localparam logic [1:0] ClassFour = 2'd3;

   typedef struct packed {
      logic                  valid_res;
      logic [CountWidth-1:0] byte_count;
   } utv_result_type;

   function automatic logic [CpWidth-1:0] class_minimum(input logic [1:0] cls);
      logic [CpWidth-1:0] m;
      unique case (cls)
         ClassTwo:   m = 21'h000080;
         ClassThree: m = 21'h000800;
         default:    m = 21'h010000;
      endcase
      return m;
   endfunction

endpackage

### rtl/utv_step.sv
module utv_step
   import utv_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  go,
   input  logic [ByteWidth-1:0]  text_byte,
   input  logic [CountWidth-1:0] max_length,
   output utv_result_type        result
);

   logic [CountWidth-1:0] seen_ff, seen_in;
   logic [1:0]            pend_ff, pend_in;
   logic [CpWidth-1:0]    cp_ff, cp_in;
   logic [1:0]            cls_ff, cls_in;
   logic                  err_ff, err_in;

   logic                  len_fail;
   logic                  dec_fail;
   logic [1:0]            pend_eff;
   logic [CpWidth-1:0]    cp_eff;
   logic [1:0]            cls_eff;
   logic [CpWidth-1:0]    cp_shift;

   always_comb begin
      seen_in  = seen_ff;
      pend_in  = pend_ff;
      cp_in    = cp_ff;
      cls_in   = cls_ff;
      err_in   = err_ff;
      len_fail = 1'b0;
      dec_fail = 1'b0;
      pend_eff = pend_ff;
      cp_eff   = cp_ff;
      cls_eff  = cls_ff;
      cp_shift = {cp_ff[CpWidth-7:0], text_byte[5:0]};
      if (go) begin
         if (text_byte == '0) begin
            seen_in = '0;
            pend_in = '0;
            cp_in   = '0;
            cls_in  = ClassNone;
            err_in  = 1'b0;
         end else begin
            if (seen_ff == CountMax) begin
               len_fail = 1'b1;
            end else begin
               seen_in = seen_ff + 1'b1;
            end
            // a length error drops the pending sequence before decoding
            if (len_fail) begin
               pend_eff = '0;
               cp_eff   = '0;
               cls_eff  = ClassNone;
            end
            pend_in  = pend_eff;
            cp_in    = cp_eff;
            cls_in   = cls_eff;
            cp_shift = {cp_eff[CpWidth-7:0], text_byte[5:0]};
            if (pend_eff != 2'd0) begin
               if (text_byte[7:6] != 2'b10) begin
                  dec_fail = 1'b1;
               end else begin
                  pend_in = pend_eff - 2'd1;
                  cp_in   = cp_shift;
                  if (pend_eff == 2'd1) begin
                     if (cp_shift < class_minimum(cls_eff) || cp_shift > CpMax ||
                         (cp_shift >= SurrLow && cp_shift <= SurrHigh)) begin
                        dec_fail = 1'b1;
                     end
                     cp_in  = '0;
                     cls_in = ClassNone;
                  end
               end
            end else if (text_byte < CtrlLimit || text_byte == DelByte) begin
               dec_fail = 1'b1;
            end else if (!text_byte[7]) begin
               // plain ascii, nothing to track
            end else if (text_byte >= Lead2Low && text_byte <= Lead2High) begin
               pend_in = 2'd1;
               cp_in   = CpWidth'(text_byte[4:0]);
               cls_in  = ClassTwo;
            end else if (text_byte >= Lead3Low && text_byte <= Lead3High) begin
               pend_in = 2'd2;
               cp_in   = CpWidth'(text_byte[3:0]);
               cls_in  = ClassThree;
            end else if (text_byte >= Lead4Low && text_byte <= Lead4High) begin
               pend_in = 2'd3;
               cp_in   = CpWidth'(text_byte[2:0]);
               cls_in  = ClassFour;
            end else begin
               dec_fail = 1'b1;
            end
            if (len_fail || dec_fail) begin
               err_in  = 1'b1;
               pend_in = '0;
               cp_in   = '0;
               cls_in  = ClassNone;
            end
         end
      end
   end

   // verdict from the state as it stands when the terminator arrives
   assign result.valid_res = !err_ff && (pend_ff == 2'd0) && (seen_ff != '0) &&
                             (seen_ff <= max_length);
   assign result.byte_count = seen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
         pend_ff <= '0;
         cp_ff   <= '0;
         cls_ff  <= ClassNone;
         err_ff  <= 1'b0;
      end else begin
         seen_ff <= seen_in;
         pend_ff <= pend_in;
         cp_ff   <= cp_in;
         cls_ff  <= cls_in;
         err_ff  <= err_in;
      end
   end

   a_term_clears: assert property (@(posedge clock) disable iff (reset)
      go && text_byte == '0 |=> seen_ff == '0 && !err_ff && pend_ff == 2'd0)
      else $error("string state not cleared after terminator");

   a_idle_decoder: assert property (@(posedge clock) disable iff (reset)
      pend_ff == 2'd0 |-> cls_ff == ClassNone && cp_ff == '0)
      else $error("decoder holds a partial code point with nothing pending");

   a_pending_class: assert property (@(posedge clock) disable iff (reset)
      pend_ff != 2'd0 |-> cls_ff != ClassNone && pend_ff <= cls_ff)
      else $error("pending count does not fit the sequence class");

endmodule

### rtl/utv_out.sv
module utv_out
   import utv_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           load,
   input  utv_result_type result,
   output logic           free,
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   output logic [DataWidth-1:0] rsp_tdata
);

   logic           valid_ff, valid_in;
   utv_result_type data_ff;

   assign free     = !valid_ff || rsp_tready;
   assign valid_in = load || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {{(DataWidth - CountWidth - 1){1'b0}}, data_ff.byte_count,
                        data_ff.valid_res};

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !rsp_tready |-> !load)
      else $error("result register overwritten while stalled");

   a_valid_has_count: assert property (@(posedge clock) disable iff (reset)
      valid_ff && data_ff.valid_res |-> data_ff.byte_count != '0)
      else $error("valid verdict on an empty string");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load |=> valid_ff)
      else $error("loaded result not presented");

endmodule

### rtl/utf8_text_validator.sv
// utf8 text validator: checks zero-terminated strings streamed one byte per
// transaction on the req_ channel and returns one verdict per string on rsp_.
// req_tdata[7:0] is the text byte; a zero byte ends the string and gives
// exactly one rsp_ transaction, other bytes give none.
// rsp_tdata: bit 0 valid_res, bits 16:1 byte_count (saturating at 65535),
// bits 23:17 zero.
// csr_ writes max_length (16 bit, reset 160) and is always ready; write it
// only while no string is in flight.
// a terminator accepted on req_ passes the input register and then the result
// register before it shows on rsp_ (one input register, one result register).
// throughput: one byte per cycle unless a terminator waits on the result register;
// the decoder state update is a single registered step, so bytes flow back to back.
// reset clears the string state, both pipeline valids and sets max_length
// back to 160.
// when rsp_tready is low the result register holds; non-zero bytes keep
// flowing, and a second terminator waits in the input register until the
// result register frees.
module utf8_text_validator
   import utv_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [ByteWidth-1:0]  req_tdata,   // [7:0] text_byte
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [DataWidth-1:0]  rsp_tdata,   // [0] valid_res, [16:1] byte_count
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CountWidth-1:0] csr_data     // [15:0] max_length
);

   logic                  s1_valid_ff, s1_valid_in;
   logic [ByteWidth-1:0]  s1_byte_ff;
   logic [CountWidth-1:0] max_len_ff;
   logic                  out_free;
   logic                  s1_go;
   logic                  s1_term;
   utv_result_type        result;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MaxLenReset;
      end else if (csr_valid) begin
         max_len_ff <= csr_data;
      end
   end

   // non-zero bytes never need the result register
   assign s1_term     = s1_byte_ff == '0;
   assign s1_go       = s1_valid_ff && (!s1_term || out_free);
   assign req_tready  = !s1_valid_ff || s1_go;
   assign s1_valid_in = (req_tvalid && req_tready) || (s1_valid_ff && !s1_go);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_byte_ff <= req_tdata;
      end
   end

   utv_step u_step (
      .clock      (clock),
      .reset      (reset),
      .go         (s1_go),
      .text_byte  (s1_byte_ff),
      .max_length (max_len_ff),
      .result     (result)
   );

   utv_out u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (s1_go && s1_term),
      .result     (result),
      .free       (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
